// ===== hdl/gsef_pkg.sv =====
`default_nettype none

package gsef_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd480;

  // floor(x / 159) = (x * 105518) >> 24 for x < 2^16
  localparam logic [16:0] GAUSS_NORM_MUL   = 17'd105518;
  localparam int unsigned GAUSS_NORM_SHIFT = 24;
  localparam logic [15:0] GAUSS_SUM_MAX    = 16'd40545;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALC,
    ST_BLUR_RD,
    ST_BLUR_DRAIN,
    ST_BLUR_DIV,
    ST_BLUR_WR,
    ST_WIN_RD,
    ST_WIN_DRAIN,
    ST_GRAD,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQRT,
    ST_EMIT,
    ST_DONE
  } gsef_state_e;

  function automatic logic [3:0] gauss_weight(input logic [2:0] ti, input logic [2:0] tj);
    logic [1:0] fi;
    logic [1:0] fj;
    logic [3:0] w;
    fi = (ti > 3'd2) ? 2'(3'd4 - ti) : ti[1:0];
    fj = (tj > 3'd2) ? 2'(3'd4 - tj) : tj[1:0];
    case ({fi, fj})
      4'b0000: w = 4'd2;
      4'b0001: w = 4'd4;
      4'b0010: w = 4'd5;
      4'b0100: w = 4'd4;
      4'b0101: w = 4'd9;
      4'b0110: w = 4'd12;
      4'b1000: w = 4'd5;
      4'b1001: w = 4'd12;
      4'b1010: w = 4'd15;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gaussian_sobel_edge_filter_unit.sv =====
// Gaussian 5x5 blur then Sobel 3x3 magnitude over a raster pixel stream.
// One request at a time; one that neither blurs nor emits ends after CALC.
// Blurring walks 25 serial raw line store read steps, emitting 9 blur store read
// steps, an interior-only 13-step root; results trail pixels by 3*W+3 requests.
// Reset clears the sequencer, position counters and output register, and sets
// the geometry to 640x480; line store contents are not cleared.
`default_nettype none

module gaussian_sobel_edge_filter_unit #(
  parameter int unsigned MaxWidth  = gsef_pkg::MAX_WIDTH,
  parameter int unsigned MaxHeight = gsef_pkg::MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [gsef_pkg::PIX_W-1:0]      pixel_value_i,
  input  logic                            flush_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [gsef_pkg::PIX_W-1:0]      blurred_pixel_o,
  output logic [gsef_pkg::PIX_W-1:0]      edge_magnitude_o,
  output logic                            frame_last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gsef_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gsef_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gsef_pkg::*;

  localparam int unsigned WW        = $clog2(MaxWidth + 1);
  localparam int unsigned CW        = $clog2(MaxWidth);
  localparam int unsigned HW        = $clog2(MaxHeight + 1);
  localparam int unsigned KW        = $clog2(MaxWidth * MaxHeight + 3 * MaxWidth + 4);
  localparam int unsigned RawDepth  = 6 * MaxWidth;
  localparam int unsigned BlurDepth = 4 * MaxWidth;
  localparam int unsigned RawAw     = $clog2(RawDepth);
  localparam int unsigned BlurAw    = $clog2(BlurDepth);

  function automatic logic [2:0] mod6(input logic [3:0] v);
    logic [3:0] r;
    if (v >= 4'd12) r = v - 4'd12;
    else if (v >= 4'd6) r = v - 4'd6;
    else r = v;
    return r[2:0];
  endfunction

  gsef_state_e state_q, state_d;

  logic [CFG_DATA_W-1:0] w_reg_q, h_reg_q;
  logic [WW-1:0]         w_eff;
  logic [HW-1:0]         h_eff;
  logic [KW-1:0]         total_q, k_q, lag_b, lag_o;

  logic [CW-1:0] col_q;
  logic [2:0]    rslot_q;
  logic [HW-1:0] brow_q;
  logic [CW-1:0] bcol_q;
  logic [2:0]    bs6_q;
  logic [1:0]    bs4_q;
  logic [HW-1:0] orow_q;
  logic [CW-1:0] ocol_q;
  logic [1:0]    os4_q;

  logic [7:0] pix_q;
  logic       do_out_q, interior_q, last_q;
  logic       wr_raw, blur_act, out_act, interior_c, last_c;

  logic [2:0]  ti_q, tj_q;
  logic        pv_q;
  logic [3:0]  pw_q, pidx_q;
  logic [15:0] acc_q;
  logic [32:0] prod_q;
  logic [7:0]  win_q [9];
  logic [9:0]  ax_q, ay_q;
  logic [20:0] sq_q;
  logic [12:0] r_q, bit_q, sq_t;
  logic [25:0] sq_tt;

  logic signed [11:0] gx, gy;
  logic [7:0]         mag;

  logic              raw_we, raw_re, blur_we, win_re;
  logic [RawAw-1:0]  raw_waddr, raw_raddr;
  logic [BlurAw-1:0] blur_waddr, blur_raddr;
  logic [7:0]        raw_rdata, blur_rdata, blur_val;
  logic [HW:0]       tap_row;
  logic [WW:0]       tap_col, win_col;
  logic              row_ok, col_ok, tap_last, win_last;
  logic [2:0]        raw_slot;
  logic [1:0]        win_slot;

  logic       in_acc, cfg_wr, emit_load;
  logic       out_valid_q, frame_last_q;
  logic [7:0] blurred_q, mag_q;

  // geometry
  always_comb begin
    if (w_reg_q < 11'd3) w_eff = WW'(3);
    else if (32'(w_reg_q) > MaxWidth) w_eff = WW'(MaxWidth);
    else w_eff = WW'(w_reg_q);
    if (h_reg_q < 11'd3) h_eff = HW'(3);
    else if (32'(h_reg_q) > MaxHeight) h_eff = HW'(MaxHeight);
    else h_eff = HW'(h_reg_q);
  end

  assign lag_b = (KW'(w_eff) << 1) + KW'(2);
  assign lag_o = lag_b + KW'(w_eff) + KW'(1);

  assign wr_raw     = k_q < total_q;
  assign blur_act   = (k_q >= lag_b) && ((k_q - lag_b) < total_q);
  assign out_act    = (k_q >= lag_o) && ((k_q - lag_o) < total_q);
  assign last_c     = out_act && (orow_q == h_eff - HW'(1)) && (WW'(ocol_q) == w_eff - WW'(1));
  assign interior_c = (orow_q != '0) && (orow_q != h_eff - HW'(1)) &&
                      (ocol_q != '0) && (WW'(ocol_q) != w_eff - WW'(1));

  // tap addressing
  assign tap_row  = (HW+1)'(brow_q) + (HW+1)'(ti_q);
  assign tap_col  = (WW+1)'(bcol_q) + (WW+1)'(tj_q);
  assign row_ok   = (tap_row >= (HW+1)'(2)) && ((tap_row - (HW+1)'(2)) < (HW+1)'(h_eff));
  assign col_ok   = (tap_col >= (WW+1)'(2)) && ((tap_col - (WW+1)'(2)) < (WW+1)'(w_eff));
  assign raw_slot = mod6(4'(bs6_q) + 4'(ti_q) + 4'd4);
  assign tap_last = (ti_q == 3'd4) && (tj_q == 3'd4);
  assign win_last = (ti_q == 3'd2) && (tj_q == 3'd2);
  assign win_slot = 2'(os4_q + ti_q[1:0] + 2'd3);
  assign win_col  = (WW+1)'(ocol_q) + (WW+1)'(tj_q) - (WW+1)'(1);

  assign raw_waddr  = RawAw'(rslot_q) * RawAw'(MaxWidth) + RawAw'(col_q);
  assign raw_raddr  = RawAw'(raw_slot) * RawAw'(MaxWidth) + RawAw'(CW'(tap_col - (WW+1)'(2)));
  assign blur_waddr = BlurAw'(bs4_q) * BlurAw'(MaxWidth) + BlurAw'(bcol_q);
  assign blur_raddr = BlurAw'(win_slot) * BlurAw'(MaxWidth) + BlurAw'(CW'(win_col));
  assign blur_val   = prod_q[GAUSS_NORM_SHIFT +: 8];

  assign in_acc    = in_valid_i && !in_stall_o;
  assign cfg_wr    = cfg_valid_i && cfg_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:       if (in_acc) state_d = ST_CALC;
      ST_CALC: begin
        if (blur_act) state_d = ST_BLUR_RD;
        else if (out_act) state_d = ST_WIN_RD;
        else state_d = ST_DONE;
      end
      ST_BLUR_RD:    if (tap_last) state_d = ST_BLUR_DRAIN;
      ST_BLUR_DRAIN: state_d = ST_BLUR_DIV;
      ST_BLUR_DIV:   state_d = ST_BLUR_WR;
      ST_BLUR_WR:    state_d = do_out_q ? ST_WIN_RD : ST_DONE;
      ST_WIN_RD:     if (win_last) state_d = ST_WIN_DRAIN;
      ST_WIN_DRAIN:  state_d = interior_q ? ST_GRAD : ST_EMIT;
      ST_GRAD:       state_d = ST_SQ_X;
      ST_SQ_X:       state_d = ST_SQ_Y;
      ST_SQ_Y:       state_d = ST_SQRT;
      ST_SQRT:       if (bit_q[0]) state_d = ST_EMIT;
      ST_EMIT:       if (!out_valid_q || !out_stall_i) state_d = ST_DONE;
      ST_DONE:       state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    cfg_ready_o = (state_q == ST_IDLE);
    raw_we      = (state_q == ST_CALC) && wr_raw;
    raw_re      = (state_q == ST_BLUR_RD) && row_ok && col_ok;
    blur_we     = (state_q == ST_BLUR_WR);
    win_re      = (state_q == ST_WIN_RD) &&
                  (interior_q || ((ti_q == 3'd1) && (tj_q == 3'd1)));
    emit_load   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  end

  gsef_ram #(
    .Width(8),
    .Depth(RawDepth),
    .AddrW(RawAw)
  ) u_raw_ram (
    .clk_i  (clk_i),
    .we_i   (raw_we),
    .waddr_i(raw_waddr),
    .wdata_i(pix_q),
    .re_i   (raw_re),
    .raddr_i(raw_raddr),
    .rdata_o(raw_rdata)
  );

  gsef_ram #(
    .Width(8),
    .Depth(BlurDepth),
    .AddrW(BlurAw)
  ) u_blur_ram (
    .clk_i  (clk_i),
    .we_i   (blur_we),
    .waddr_i(blur_waddr),
    .wdata_i(blur_val),
    .re_i   (win_re),
    .raddr_i(blur_raddr),
    .rdata_o(blur_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      w_reg_q     <= WIDTH_RESET;
      h_reg_q     <= HEIGHT_RESET;
      total_q     <= '0;
      k_q         <= '0;
      col_q       <= '0;
      rslot_q     <= '0;
      brow_q      <= '0;
      bcol_q      <= '0;
      bs6_q       <= '0;
      bs4_q       <= '0;
      orow_q      <= '0;
      ocol_q      <= '0;
      os4_q       <= '0;
      do_out_q    <= 1'b0;
      interior_q  <= 1'b0;
      last_q      <= 1'b0;
      pv_q        <= 1'b0;
      ti_q        <= '0;
      tj_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= KW'(w_eff) * KW'(h_eff);
      pv_q    <= raw_re || win_re;

      if ((state_q == ST_BLUR_RD) || (state_q == ST_WIN_RD)) begin
        if (tj_q == ((state_q == ST_BLUR_RD) ? 3'd4 : 3'd2)) begin
          tj_q <= '0;
          ti_q <= ti_q + 3'd1;
        end else begin
          tj_q <= tj_q + 3'd1;
        end
      end else begin
        ti_q <= '0;
        tj_q <= '0;
      end

      if (state_q == ST_CALC) begin
        do_out_q   <= out_act;
        interior_q <= interior_c;
        last_q     <= last_c;
      end

      if (emit_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;

      if (cfg_wr && ((cfg_index_i == REG_IMAGE_WIDTH) || (cfg_index_i == REG_IMAGE_HEIGHT))) begin
        if (cfg_index_i == REG_IMAGE_WIDTH) w_reg_q <= cfg_data_i;
        else h_reg_q <= cfg_data_i;
        k_q     <= '0;
        col_q   <= '0;
        rslot_q <= '0;
        brow_q  <= '0;
        bcol_q  <= '0;
        bs6_q   <= '0;
        bs4_q   <= '0;
        orow_q  <= '0;
        ocol_q  <= '0;
        os4_q   <= '0;
      end else if (state_q == ST_DONE) begin
        if (last_q) begin
          k_q     <= '0;
          col_q   <= '0;
          rslot_q <= '0;
          brow_q  <= '0;
          bcol_q  <= '0;
          bs6_q   <= '0;
          bs4_q   <= '0;
          orow_q  <= '0;
          ocol_q  <= '0;
          os4_q   <= '0;
        end else begin
          k_q <= k_q + KW'(1);
          if (WW'(col_q) == w_eff - WW'(1)) begin
            col_q   <= '0;
            rslot_q <= (rslot_q == 3'd5) ? 3'd0 : rslot_q + 3'd1;
          end else begin
            col_q <= col_q + CW'(1);
          end
          if (state_q == ST_DONE && k_q >= lag_b && (k_q - lag_b) < total_q) begin
            if (WW'(bcol_q) == w_eff - WW'(1)) begin
              bcol_q <= '0;
              brow_q <= brow_q + HW'(1);
              bs6_q  <= (bs6_q == 3'd5) ? 3'd0 : bs6_q + 3'd1;
              bs4_q  <= bs4_q + 2'd1;
            end else begin
              bcol_q <= bcol_q + CW'(1);
            end
          end
          if (do_out_q) begin
            if (WW'(ocol_q) == w_eff - WW'(1)) begin
              ocol_q <= '0;
              orow_q <= orow_q + HW'(1);
              os4_q  <= os4_q + 2'd1;
            end else begin
              ocol_q <= ocol_q + CW'(1);
            end
          end
        end
      end
    end
  end

  // gradient
  always_comb begin
    gx = $signed(12'(win_q[2]) + (12'(win_q[5]) << 1) + 12'(win_q[8])) -
         $signed(12'(win_q[0]) + (12'(win_q[3]) << 1) + 12'(win_q[6]));
    gy = $signed(12'(win_q[6]) + (12'(win_q[7]) << 1) + 12'(win_q[8])) -
         $signed(12'(win_q[0]) + (12'(win_q[1]) << 1) + 12'(win_q[2]));
    sq_t  = r_q | bit_q;
    sq_tt = 26'(sq_t) * 26'(sq_t);
    if (!interior_q) mag = 8'd0;
    else if (|r_q[12:8]) mag = 8'hFF;
    else mag = r_q[7:0];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) pix_q <= flush_i ? 8'd0 : pixel_value_i;
    pw_q   <= gauss_weight(ti_q, tj_q);
    pidx_q <= 4'({ti_q, 1'b0}) + 4'(ti_q) + 4'(tj_q);

    if (state_q == ST_CALC) acc_q <= '0;
    else if (pv_q && ((state_q == ST_BLUR_RD) || (state_q == ST_BLUR_DRAIN)))
      acc_q <= acc_q + 16'(pw_q) * 16'(raw_rdata);

    if (state_q == ST_BLUR_DIV) prod_q <= 33'(acc_q) * 33'(GAUSS_NORM_MUL);

    if (pv_q && ((state_q == ST_WIN_RD) || (state_q == ST_WIN_DRAIN)))
      win_q[pidx_q] <= blur_rdata;

    if (state_q == ST_GRAD) begin
      ax_q <= gx[11] ? 10'(-gx) : gx[9:0];
      ay_q <= gy[11] ? 10'(-gy) : gy[9:0];
    end
    if (state_q == ST_SQ_X) sq_q <= 21'(ax_q) * 21'(ax_q);
    if (state_q == ST_SQ_Y) begin
      sq_q  <= sq_q + 21'(ay_q) * 21'(ay_q);
      r_q   <= '0;
      bit_q <= 13'h1000;
    end
    if (state_q == ST_SQRT) begin
      if (sq_tt <= 26'(sq_q)) r_q <= sq_t;
      bit_q <= bit_q >> 1;
    end

    if (emit_load) begin
      blurred_q    <= win_q[4];
      mag_q        <= mag;
      frame_last_q <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign blurred_pixel_o  = blurred_q;
  assign edge_magnitude_o = mag_q;
  assign frame_last_o     = frame_last_q;

  a_accept_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_CALC))
    else $error("accepted request did not start");
  a_emit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> do_out_q)
    else $error("result emitted for a request without output");
  a_sqrt_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> $onehot(bit_q))
    else $error("square root bit lost");
  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLUR_DIV) |-> (acc_q <= GAUSS_SUM_MAX))
    else $error("blur sum out of range");
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && last_q && !cfg_wr) |=> ((k_q == '0) && (col_q == '0)))
    else $error("frame end did not restart position");

endmodule

`default_nettype wire

// ===== hdl/gsef_ram.sv =====
`default_nettype none

module gsef_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== tb/tb_gaussian_sobel_edge_filter_unit.sv =====
`timescale 1ns / 100ps

module tb_gaussian_sobel_edge_filter_unit;
  import gsef_pkg::*;

  typedef struct packed {
    logic [7:0] blur;
    logic [7:0] mag;
    logic       last;
  } edge_res_t;

  typedef struct packed {
    logic [7:0] pix;
    logic       fl;
    logic       typed;
    edge_res_t  res;
  } stim_row_t;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int SETTLE       = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] pixel_value = '0;
  logic flush = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] blurred_pixel;
  logic [7:0] edge_magnitude;
  logic frame_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // expectation override carried alongside the request
  logic typed_req = 1'b0;
  edge_res_t typed_res = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int fails = 0;
  int cycles = 0;

  edge_res_t expected_q[$];

  // predictor state
  logic [7:0] raw_mem[6][MAX_WIDTH];
  logic [7:0] blur_mem[4][MAX_WIDTH];
  int unsigned geo_w = WIDTH_RESET;
  int unsigned geo_h = HEIGHT_RESET;
  int unsigned pos_col = 0;
  int unsigned pos_row = 0;

  gaussian_sobel_edge_filter_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .pixel_value_i   (pixel_value),
    .flush_i         (flush),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .blurred_pixel_o (blurred_pixel),
    .edge_magnitude_o(edge_magnitude),
    .frame_last_o    (frame_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned raw_pix(input int r, input int c, input int unsigned w,
                                          input int unsigned h);
    if (r < 0 || c < 0 || r >= int'(h) || c >= int'(w)) return 0;
    return raw_mem[r % 6][c];
  endfunction

  function automatic int unsigned floor_root(input int unsigned v);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 12; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic int gauss_coef(input int i, input int j);
    int unsigned fi;
    int unsigned fj;
    fi = (i > 2) ? 4 - i : i;
    fj = (j > 2) ? 4 - j : j;
    case (fi * 3 + fj)
      0: return 2;
      1: return 4;
      2: return 5;
      3: return 4;
      4: return 9;
      5: return 12;
      6: return 5;
      7: return 12;
      default: return 15;
    endcase
  endfunction

  function automatic bit filter_step(input logic [7:0] pix, input logic fl,
                                     output edge_res_t r);
    int unsigned w, h, total, k, b, br, bc, o, orow, ocol, sum, mag;
    int p[3][3];
    int gx, gy;
    bit has;
    w = clamp_dim(geo_w, MAX_WIDTH);
    h = clamp_dim(geo_h, MAX_HEIGHT);
    total = w * h;
    k = pos_row * w + pos_col;
    has = 1'b0;
    r = '0;
    if (k < total) raw_mem[pos_row % 6][pos_col] = fl ? 8'd0 : pix;
    if (k >= 2 * w + 2 && k - (2 * w + 2) < total) begin
      b = k - (2 * w + 2);
      br = b / w;
      bc = b % w;
      sum = 0;
      for (int i = 0; i < 5; i++)
        for (int j = 0; j < 5; j++)
          sum += gauss_coef(i, j) * raw_pix(int'(br) + i - 2, int'(bc) + j - 2, w, h);
      blur_mem[br % 4][bc] = 8'(sum / 159);
    end
    if (k >= 3 * w + 3 && k - (3 * w + 3) < total) begin
      o = k - (3 * w + 3);
      orow = o / w;
      ocol = o % w;
      mag = 0;
      if (orow > 0 && orow < h - 1 && ocol > 0 && ocol < w - 1) begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            p[i][j] = blur_mem[(orow + i - 1) % 4][ocol + j - 1];
        gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
        gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
        if (gx < 0) gx = -gx;
        if (gy < 0) gy = -gy;
        mag = floor_root(gx * gx + gy * gy);
        if (mag > 255) mag = 255;
      end
      r.blur = blur_mem[orow % 4][ocol];
      r.mag = 8'(mag);
      r.last = (o == total - 1);
      has = 1'b1;
      if (o == total - 1) begin
        pos_col = 0;
        pos_row = 0;
        return has;
      end
    end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    return has;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
    fails++;
  endtask

  // request acceptance, result checking, register writes
  always @(posedge clk) begin
    edge_res_t r;
    edge_res_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", blurred_pixel, -1);
        end else begin
          e = expected_q.pop_front();
          if (blurred_pixel !== e.blur) report_mismatch("blurred_pixel", blurred_pixel, e.blur);
          if (edge_magnitude !== e.mag) report_mismatch("edge_magnitude", edge_magnitude, e.mag);
          if (frame_last !== e.last) report_mismatch("frame_last", frame_last, e.last);
        end
      end
      if (in_valid && !in_stall) begin
        if (filter_step(pixel_value, flush, r)) expected_q.push_back(typed_req ? typed_res : r);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT) begin
          if (cfg_index == REG_IMAGE_WIDTH) geo_w = cfg_data;
          else geo_h = cfg_data;
          pos_col = 0;
          pos_row = 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("gaussian_sobel_edge_filter_unit regression: fail");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [7:0] pix, input logic fl, input logic typ,
                           input edge_res_t tres);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_value <= pix;
    flush <= fl;
    typed_req <= typ;
    typed_res <= tres;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_pix();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // one frame plus drain; noise swaps flush and pixel requests
  task automatic run_frame(input int unsigned wr, input int unsigned hr, input int noise_pct,
                           input int unsigned cut);
    int unsigned w, h, n;
    w = clamp_dim(wr, MAX_WIDTH);
    h = clamp_dim(hr, MAX_HEIGHT);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, wr);
    write_reg(REG_IMAGE_HEIGHT, hr);
    n = w * h + 3 * w + 3;
    if (cut != 0 && cut < n) n = cut;
    for (int unsigned i = 0; i < n; i++) begin
      if (i < w * h)
        send_item(rand_pix(), $urandom_range(99) < noise_pct, 1'b0, '0);
      else
        send_item(rand_pix(), $urandom_range(99) >= noise_pct, 1'b0, '0);
    end
  endtask

  stim_row_t zero_frame[21];

  task automatic random_phase(input int n_items);
    int sent;
    int unsigned w, h;
    sent = 0;
    while (sent < n_items) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      run_frame(w, h, ($urandom_range(3) == 0) ? 15 : 0, 0);
      sent += w * h + 3 * w + 3;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset geometry: a few pixels, no results yet
    for (int i = 0; i < 4; i++) send_item(8'($urandom), 1'b0, 1'b0, '0);

    // all-black 3x3 frame: flush in the pixel phase acts as black,
    // a white pixel in the drain phase is ignored
    for (int i = 0; i < 21; i++) begin
      zero_frame[i] = '{pix: 8'd0, fl: (i >= 9), typed: (i >= 12), res: '0};
      if (i == 20) zero_frame[i].res.last = 1'b1;
    end
    zero_frame[4].fl = 1'b1;
    zero_frame[15].pix = 8'd255;
    zero_frame[15].fl = 1'b0;
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 3);
    write_reg(2'd2, 5);
    write_reg(2'd3, 7);
    foreach (zero_frame[i])
      send_item(zero_frame[i].pix, zero_frame[i].fl, zero_frame[i].typed, zero_frame[i].res);

    // clamped geometry, then a broken frame cut short by a register write
    run_frame(0, 2, 0, 0);
    run_frame(2047, 1, 0, 40);
    run_frame(5, 4, 10, 0);

    send_idle_pct = 21;
    recv_stall_pct = 68;
    random_phase(130);

    send_idle_pct = 68;
    recv_stall_pct = 21;
    random_phase(130);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    // long receiver hold once results start, while requests keep coming
    fork
      run_frame(8, 6, 0, 0);
      begin
        while (expected_q.size() == 0) @(negedge clk);
        hold_req = 1'b1;
      end
    join
    random_phase(130);
    run_frame(3, 1024, 0, 150);

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (fails == 0) begin
      $display("gaussian_sobel_edge_filter_unit regression: pass");
    end else begin
      $display("gaussian_sobel_edge_filter_unit regression: fail");
    end
    $finish;
  end

endmodule
